// ----- rtl/gnce_pkg.sv -----
package gnce_pkg;

  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 256;
  localparam int CNT_W    = 9;
  localparam int COORD_W  = 8;
  localparam int IDX_W    = 16;
  localparam int PROD_W   = COORD_W + CNT_W;
  localparam int SLOTS    = 9;

  typedef enum logic [1:0] {
    OP_NINE = 2'd0,
    OP_FWD  = 2'd1,
    OP_REV  = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  localparam logic REG_GRID_COLS = 1'b0;
  localparam logic REG_GRID_ROWS = 1'b1;

  localparam logic [3:0] FWD_FIRST_STR  = 4'd7;
  localparam logic [3:0] FWD_FIRST_DIAG = 4'd6;
  localparam logic [3:0] REV_FIRST_STR  = 4'd3;
  localparam logic [3:0] REV_FIRST_DIAG = 4'd2;
  localparam logic [3:0] CNT_NINE       = 4'd9;
  localparam logic [3:0] CNT_STR        = 4'd3;
  localparam logic [3:0] CNT_DIAG       = 4'd5;

  typedef logic [SLOTS-1:0][3:0] slot_list_t;

  typedef struct packed {
    logic [SLOTS-1:0] mask;
    slot_list_t       slot;
    logic [IDX_W-1:0] base;
    logic [CNT_W-1:0] cols;
  } gnce_job_t;

  function automatic logic [3:0] slot_count(opcode_t op, logic [2:0] dir);
    logic [3:0] n;
    case (op)
      OP_NINE: n = CNT_NINE;
      OP_FWD:  n = dir[0] ? CNT_DIAG : CNT_STR;
      OP_REV:  n = dir[0] ? CNT_DIAG : CNT_STR;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] slot_off(opcode_t op, logic [2:0] dir, logic [3:0] j);
    logic [3:0] first;
    logic [3:0] sum;
    logic [3:0] k;
    case (op)
      OP_FWD:  first = dir[0] ? FWD_FIRST_DIAG : FWD_FIRST_STR;
      OP_REV:  first = dir[0] ? REV_FIRST_DIAG : REV_FIRST_STR;
      default: first = 4'd0;
    endcase
    sum = first + j + {1'b0, dir};
    if (op == OP_NINE) begin
      k = j;
    end else begin
      k = {1'b0, sum[2:0]};
    end
    return k;
  endfunction

  function automatic logic signed [1:0] off_dx(logic [3:0] k);
    logic signed [1:0] d;
    case (k)
      4'd1, 4'd2, 4'd3: d = 2'sd1;
      4'd5, 4'd6, 4'd7: d = -2'sd1;
      default:          d = 2'sd0;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] off_dy(logic [3:0] k);
    logic signed [1:0] d;
    case (k)
      4'd0, 4'd1, 4'd7: d = -2'sd1;
      4'd3, 4'd4, 4'd5: d = 2'sd1;
      default:          d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/gnce_emit.sv -----
module gnce_emit
  import gnce_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  input  gnce_job_t        job,
  output logic             job_ready,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [IDX_W-1:0] out_neighbour_index,
  output logic             out_found,
  output logic             out_last_of_run
);

  logic             e_valid_r;
  gnce_job_t        e_job_r;
  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic             out_found_r;
  logic             out_last_r;

  logic [3:0]       sel;
  logic [SLOTS-1:0] rem;
  logic             any;
  logic             last;
  logic [3:0]       k;
  logic signed [1:0] dx;
  logic signed [1:0] dy;
  logic [IDX_W-1:0] row_adj;
  logic [IDX_W-1:0] idx_nxt;
  logic             out_load;
  logic             e_fire;

  always_comb begin
    sel = '0;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (e_job_r.mask[j]) begin
        sel = 4'(j);
      end
    end
    any = |e_job_r.mask;
    rem = e_job_r.mask;
    if (any) begin
      rem[sel] = 1'b0;
    end
    last = (rem == '0);
    k    = e_job_r.slot[sel];
    dx   = off_dx(k);
    dy   = off_dy(k);
    if (dy == -2'sd1) begin
      row_adj = IDX_W'(0) - IDX_W'(e_job_r.cols);
    end else if (dy == 2'sd1) begin
      row_adj = IDX_W'(e_job_r.cols);
    end else begin
      row_adj = '0;
    end
    idx_nxt = e_job_r.base + row_adj + {{(IDX_W-2){dx[1]}}, dx};
  end

  assign out_load  = !out_valid_r || !out_stall;
  assign e_fire    = e_valid_r && out_load;
  assign job_ready = !e_valid_r || (e_fire && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (job_ready) begin
        e_valid_r <= job_valid;
      end
      if (out_load) begin
        out_valid_r <= e_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      e_job_r <= job;
    end else if (e_fire) begin
      e_job_r.mask <= rem;
    end
    if (e_fire) begin
      out_idx_r   <= any ? idx_nxt : '0;
      out_found_r <= any;
      out_last_r  <= last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_neighbour_index = out_idx_r;
  assign out_found           = out_found_r;
  assign out_last_of_run     = out_last_r;

endmodule

// ----- rtl/grid_neighbour_cell_enumerator_unit.sv -----
// Grid neighbour cell enumerator.
// Input channel (in_valid / in_stall): one query item per accept, carrying
// opcode (nine-cell set, forward set, reverse set), move direction and the
// centre cell column and row.
// Result channel (out_valid / out_stall): one item per in-bounds cell of the
// chosen set, in set order, with the linear index row * cols + col and
// found = 1; the final item of a query has last_of_run = 1. A query whose set
// is empty gives one item with found = 0, index 0 and last_of_run = 1.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_wdata): index 0 sets
// the column count, index 1 the row count; counts above 256 act as 256.
// cfg_ready is always high; write only while no query is in flight.
// A query moves through s1, s2, s3, the serializer job register and the result
// register in that order. A query yields max(1, n) items on the single result
// port, n = in-bounds cells (up to 9); the input stages keep accepting until the
// result serializer and the three stages ahead of it are full.
// Reset (synchronous, rst_n low): pipeline emptied, counts back to 16x16.
// A stalled result holds its payload; back-pressure reaches in_stall through
// the pipeline without dropping or repeating items.
module grid_neighbour_cell_enumerator_unit
  import gnce_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [2:0]         in_direction,
  input  logic [COORD_W-1:0] in_cell_col,
  input  logic [COORD_W-1:0] in_cell_row,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [IDX_W-1:0]   out_neighbour_index,
  output logic               out_found,
  output logic               out_last_of_run,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [CNT_W-1:0]   cfg_wdata
);

  logic [CNT_W-1:0]   grid_cols_r;
  logic [CNT_W-1:0]   grid_rows_r;
  logic [CNT_W-1:0]   cols_eff;
  logic [CNT_W-1:0]   rows_eff;

  logic               s1_valid_r;
  opcode_t            s1_op_r;
  logic [2:0]         s1_dir_r;
  logic [COORD_W-1:0] s1_col_r;
  logic [COORD_W-1:0] s1_row_r;

  logic               s2_valid_r;
  logic [SLOTS-1:0]   s2_mask_r;
  slot_list_t         s2_slot_r;
  logic [PROD_W-1:0]  s2_prod_r;
  logic [COORD_W-1:0] s2_col_r;
  logic [CNT_W-1:0]   s2_cols_r;

  logic               s3_valid_r;
  gnce_job_t          s3_job_r;

  logic [SLOTS-1:0]   mask_nxt;
  slot_list_t         slot_nxt;
  logic [PROD_W-1:0]  prod_nxt;
  gnce_job_t          job_nxt;

  logic               e_ready;
  logic               s1_en;
  logic               s2_en;
  logic               s3_en;

  assign cols_eff = (grid_cols_r > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : grid_cols_r;
  assign rows_eff = (grid_rows_r > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : grid_rows_r;

  assign s3_en    = !s3_valid_r || e_ready;
  assign s2_en    = !s2_valid_r || s3_en;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_stall = !s1_en;
  assign cfg_ready = 1'b1;

  // slot expansion and bounds test
  always_comb begin
    logic [3:0]        n;
    logic [3:0]        k;
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic [9:0]        x;
    logic [9:0]        y;
    n = slot_count(s1_op_r, s1_dir_r);
    for (int j = 0; j < SLOTS; j++) begin
      k  = slot_off(s1_op_r, s1_dir_r, 4'(j));
      dx = off_dx(k);
      dy = off_dy(k);
      x  = {2'b00, s1_col_r} + {{8{dx[1]}}, dx};
      y  = {2'b00, s1_row_r} + {{8{dy[1]}}, dy};
      slot_nxt[j] = k;
      mask_nxt[j] = (4'(j) < n) && !x[9] && !y[9] &&
                    (x[8:0] < cols_eff) && (y[8:0] < rows_eff);
    end
    prod_nxt = PROD_W'(s1_row_r) * PROD_W'(cols_eff);
  end

  always_comb begin
    job_nxt.mask = s2_mask_r;
    job_nxt.slot = s2_slot_r;
    job_nxt.base = IDX_W'(s2_prod_r + PROD_W'(s2_col_r));
    job_nxt.cols = s2_cols_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= CNT_W'(16);
      grid_rows_r <= CNT_W'(16);
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_GRID_COLS) begin
          grid_cols_r <= cfg_wdata;
        end
        if (cfg_index == REG_GRID_ROWS) begin
          grid_rows_r <= cfg_wdata;
        end
      end
      if (s1_en) begin
        s1_valid_r <= in_valid;
      end
      if (s2_en) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_en) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_op_r  <= opcode_t'(in_opcode);
      s1_dir_r <= in_direction;
      s1_col_r <= in_cell_col;
      s1_row_r <= in_cell_row;
    end
    if (s2_en && s1_valid_r) begin
      s2_mask_r <= mask_nxt;
      s2_slot_r <= slot_nxt;
      s2_prod_r <= prod_nxt;
      s2_col_r  <= s1_col_r;
      s2_cols_r <= cols_eff;
    end
    if (s3_en && s2_valid_r) begin
      s3_job_r <= job_nxt;
    end
  end

  gnce_emit u_emit (
    .clk                 (clk),
    .rst_n               (rst_n),
    .job_valid           (s3_valid_r),
    .job                 (s3_job_r),
    .job_ready           (e_ready),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_neighbour_index (out_neighbour_index),
    .out_found           (out_found),
    .out_last_of_run     (out_last_of_run)
  );

endmodule

// ----- rtl/gnce_checker.sv -----
module gnce_checker
  import gnce_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [IDX_W-1:0]   out_neighbour_index,
  input logic               out_found,
  input logic               out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_neighbour_index) &&
    $stable(out_found) && $stable(out_last_of_run))
    else $error("result changed while stalled");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last_of_run)
    else $error("empty result not marked last");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_neighbour_index == '0)
    else $error("empty result with nonzero index");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind grid_neighbour_cell_enumerator_unit gnce_checker u_gnce_checker (.*);

// ----- dv/tb_grid_neighbour_cell_enumerator_unit.sv -----
`timescale 1ns / 100ps

module tb_grid_neighbour_cell_enumerator_unit
  import gnce_pkg::*;
();

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 16;

  typedef enum logic [1:0] {ACT_QUERY, ACT_WRITE, ACT_DRAIN} act_kind_t;

  typedef struct {
    act_kind_t  kind;
    opcode_t    opcode;
    logic [2:0] dir;
    logic [7:0] col;
    logic [7:0] row;
    logic       reg_idx;
    logic [8:0] value;
  } pending_op_t;

  typedef struct {
    logic [15:0] index;
    logic        found;
    logic        last;
  } cell_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_opcode = '0;
  logic [2:0]         in_direction = '0;
  logic [COORD_W-1:0] in_cell_col = '0;
  logic [COORD_W-1:0] in_cell_row = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [IDX_W-1:0]   out_neighbour_index;
  logic               out_found;
  logic               out_last_of_run;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = 1'b0;
  logic [CNT_W-1:0]   cfg_wdata = '0;

  pending_op_t  pending_ops[$];
  cell_result_t expected_cells[$];

  logic [8:0] grid_cols_q = 9'd16;
  logic [8:0] grid_rows_q = 9'd16;
  int         step_dx[9] = '{0, 1, 1, 1, 0, -1, -1, -1, 0};
  int         step_dy[9] = '{-1, -1, 0, 1, 1, 1, 0, -1, 0};

  logic query_taken = 1'b0;
  logic cfg_taken = 1'b0;
  int   quiet_cycles = 0;
  int   queries_sent = 0;
  int   cells_seen = 0;
  int   idle_cycles = 0;
  int   errors = 0;

  grid_neighbour_cell_enumerator_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_direction        (in_direction),
    .in_cell_col         (in_cell_col),
    .in_cell_row         (in_cell_row),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_neighbour_index (out_neighbour_index),
    .out_found           (out_found),
    .out_last_of_run     (out_last_of_run),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #2 clk = ~clk;

  task automatic enumerate_cells(input opcode_t op, input logic [2:0] dir,
                                 input logic [7:0] cx, input logic [7:0] cy);
    int cols;
    int rows;
    int first;
    int last;
    int k;
    int x;
    int y;
    int idx;
    int n;
    int offs[$];
    cell_result_t c;
    cols = (grid_cols_q > MAX_COLS) ? MAX_COLS : int'(grid_cols_q);
    rows = (grid_rows_q > MAX_ROWS) ? MAX_ROWS : int'(grid_rows_q);
    n = 0;
    case (op)
      OP_NINE: begin
        for (int i = 0; i < 9; i++) offs = {offs, i};
      end
      OP_FWD, OP_REV: begin
        if (op == OP_FWD) begin
          first = dir[0] ? int'(FWD_FIRST_DIAG) : int'(FWD_FIRST_STR);
        end else begin
          first = dir[0] ? int'(REV_FIRST_DIAG) : int'(REV_FIRST_STR);
        end
        last = first + (dir[0] ? int'(CNT_DIAG) : int'(CNT_STR)) - 1;
        for (int i = first; i <= last; i++) offs = {offs, (i + int'(dir)) % 8};
      end
      default: ;
    endcase
    foreach (offs[j]) begin
      k = offs[j];
      x = int'(cx) + step_dx[k];
      y = int'(cy) + step_dy[k];
      if (x >= 0 && y >= 0 && x < cols && y < rows) begin
        idx = y * cols + x;
        c.index = 16'(idx);
        c.found = 1'b1;
        c.last = 1'b0;
        expected_cells = {expected_cells, c};
        n++;
      end
    end
    if (n == 0) begin
      c.index = '0;
      c.found = 1'b0;
      c.last = 1'b1;
      expected_cells = {expected_cells, c};
    end else begin
      expected_cells[expected_cells.size() - 1].last = 1'b1;
    end
  endtask

  task automatic add_query(input opcode_t op, input logic [2:0] dir,
                           input logic [7:0] col, input logic [7:0] row);
    pending_op_t p;
    p.kind = ACT_QUERY;
    p.opcode = op;
    p.dir = dir;
    p.col = col;
    p.row = row;
    p.reg_idx = 1'b0;
    p.value = '0;
    pending_ops = {pending_ops, p};
  endtask

  task automatic add_write(input logic reg_idx, input logic [8:0] value);
    pending_op_t p;
    p.kind = ACT_WRITE;
    p.opcode = OP_NINE;
    p.dir = '0;
    p.col = '0;
    p.row = '0;
    p.reg_idx = reg_idx;
    p.value = value;
    pending_ops = {pending_ops, p};
  endtask

  task automatic add_drain();
    pending_op_t p;
    p.kind = ACT_DRAIN;
    p.opcode = OP_NINE;
    p.dir = '0;
    p.col = '0;
    p.row = '0;
    p.reg_idx = 1'b0;
    p.value = '0;
    pending_ops = {pending_ops, p};
  endtask

  function automatic logic [8:0] pick_count();
    logic [8:0] v;
    case ($urandom_range(9))
      0: v = 9'd0;
      1: v = 9'($urandom_range(257, 511));
      2: v = 9'd256;
      3: v = 9'($urandom_range(200, 255));
      default: v = 9'($urandom_range(1, 20));
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pick_coord(input logic [8:0] count);
    int eff;
    int v;
    eff = (count > 256) ? 256 : int'(count);
    if (eff == 0) begin
      v = $urandom_range(0, 3);
    end else begin
      case ($urandom_range(9))
        0: v = $urandom_range(0, 255);
        1: v = (eff > 255) ? 255 : eff;
        2: v = 0;
        3: v = eff - 1;
        default: v = $urandom_range(0, eff - 1);
      endcase
    end
    return 8'(v);
  endfunction

  function automatic opcode_t pick_opcode();
    if ($urandom_range(19) == 0) begin
      return OP_NONE;
    end
    return opcode_t'($urandom_range(0, 2));
  endfunction

  // input and config driver
  always @(negedge clk) begin : drive_p
    logic        nxt_valid;
    logic        nxt_cfg;
    logic        quiet;
    pending_op_t p;
    nxt_valid = in_valid && !query_taken;
    nxt_cfg = cfg_valid && !cfg_taken;
    quiet = quiet_cycles >= SETTLE_CYCLES;
    if (rst_n && !nxt_valid && !nxt_cfg && pending_ops.size() > 0) begin
      case (pending_ops[0].kind)
        ACT_QUERY: begin
          if ((queries_sent >= 120 && queries_sent < 220) || $urandom_range(99) >= 31) begin
            p = pending_ops.pop_front();
            in_opcode <= p.opcode;
            in_direction <= p.dir;
            in_cell_col <= p.col;
            in_cell_row <= p.row;
            nxt_valid = 1'b1;
            queries_sent++;
          end
        end
        ACT_WRITE: begin
          if (quiet && !query_taken) begin
            p = pending_ops.pop_front();
            cfg_index <= p.reg_idx;
            cfg_wdata <= p.value;
            nxt_cfg = 1'b1;
          end
        end
        default: begin
          if (quiet && !query_taken) begin
            void'(pending_ops.pop_front());
          end
        end
      endcase
    end
    in_valid <= nxt_valid;
    cfg_valid <= nxt_cfg;
  end

  // result sink back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (cells_seen >= 500 && cells_seen < 900) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 31);
      end
    end
  end

  // monitor, predictor hookup and checker
  always @(posedge clk) begin : monitor_p
    cell_result_t want;
    logic         out_taken;
    query_taken = rst_n && in_valid && !in_stall;
    cfg_taken = rst_n && cfg_valid && cfg_ready;
    out_taken = rst_n && out_valid && !out_stall;
    if (cfg_taken) begin
      if (cfg_index == REG_GRID_COLS) begin
        grid_cols_q = cfg_wdata;
      end else begin
        grid_rows_q = cfg_wdata;
      end
    end
    if (query_taken) begin
      enumerate_cells(opcode_t'(in_opcode), in_direction, in_cell_col, in_cell_row);
    end
    if (out_taken) begin
      cells_seen++;
      if (expected_cells.size() == 0) begin
        $error("unexpected result item: neighbour_index %0d found %0b last_of_run %0b",
               out_neighbour_index, out_found, out_last_of_run);
        errors++;
      end else begin
        want = expected_cells.pop_front();
        if (out_neighbour_index !== want.index) begin
          $error("neighbour_index: expected %0d, got %0d", want.index, out_neighbour_index);
          errors++;
        end
        if (out_found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_found);
          errors++;
        end
        if (out_last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, out_last_of_run);
          errors++;
        end
      end
    end
    if (rst_n && expected_cells.size() == 0 && !in_valid && !out_valid) begin
      quiet_cycles++;
    end else begin
      quiet_cycles = 0;
    end
    if (query_taken || cfg_taken || out_taken) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus_p
    logic [8:0] cols;
    logic [8:0] rows;

    // default 16x16 grid: corners, centre, every direction, outside centre
    add_query(OP_NINE, 3'd5, 8'd0, 8'd0);
    add_query(OP_NINE, 3'd2, 8'd15, 8'd15);
    add_query(OP_NINE, 3'd7, 8'd7, 8'd7);
    for (int d = 0; d < 8; d++) add_query(OP_FWD, 3'(d), 8'd5, 8'd5);
    for (int d = 0; d < 8; d++) add_query(OP_REV, 3'(d), 8'd0, 8'd0);
    add_query(OP_NONE, 3'd3, 8'd4, 8'd4);
    add_query(OP_NINE, 3'd0, 8'd20, 8'd3);

    add_write(REG_GRID_COLS, 9'd1);
    add_write(REG_GRID_ROWS, 9'd1);
    add_query(OP_NINE, 3'd1, 8'd0, 8'd0);

    add_write(REG_GRID_COLS, 9'd0);
    add_write(REG_GRID_ROWS, 9'd5);
    add_query(OP_NINE, 3'd0, 8'd0, 8'd1);

    add_write(REG_GRID_COLS, 9'd256);
    add_write(REG_GRID_ROWS, 9'd256);
    add_query(OP_NINE, 3'd6, 8'd255, 8'd255);
    add_query(OP_FWD, 3'd1, 8'd255, 8'd0);

    add_write(REG_GRID_COLS, 9'd511);
    add_write(REG_GRID_ROWS, 9'd300);
    add_query(OP_NINE, 3'd4, 8'd255, 8'd255);

    for (int ph = 0; ph < 8; ph++) begin
      cols = pick_count();
      rows = pick_count();
      add_write(REG_GRID_COLS, cols);
      add_write(REG_GRID_ROWS, rows);
      for (int j = 0; j < 50; j++) begin
        if (j == 25 && ph[0]) add_drain();
        add_query(pick_opcode(), 3'($urandom_range(0, 7)), pick_coord(cols), pick_coord(rows));
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_valid || cfg_valid || expected_cells.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
